// ===== hw/rtl/swhll_pkg.sv =====
// ----------------------------------------------------------------------------
// swhll_pkg
// Shared types, field widths, opcodes and helpers for the sliding-window
// HyperLogLog register store.
// ----------------------------------------------------------------------------
package swhll_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_PRECISION        = 12;
  localparam int DEF_ENTRIES_PER_REGISTER = 64;
  localparam int DEF_TIME_BITS            = 32;

  // Fixed field widths of the transaction ports.
  localparam int HASH_W       = 64;
  localparam int EVENT_TIME_W = 32;
  localparam int INDEX_W      = 12;
  localparam int WIN_W        = 32;
  localparam int RANK_W       = 6;
  localparam int PREC_CFG_W   = 4;

  localparam int                    MIN_PRECISION   = 4;
  localparam logic [PREC_CFG_W-1:0] PRECISION_RESET = 4'd12;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_ENC,
    F_RANK
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_COUNT,
    B_SCAN,
    B_APPEND,
    B_DONE
  } back_state_t;

  // Width of one queued command: {op, reg, rank, time, window}.
  function automatic int cmd_width(input int max_prec, input int time_bits);
    return 1 + max_prec + RANK_W + time_bits + WIN_W;
  endfunction

endpackage

// ===== hw/rtl/swhll_front.sv =====
// ----------------------------------------------------------------------------
// swhll_front
// Accepts transactions, holds the precision register, selects the register
// and computes the rank of an insert, then queues a command for the back end.
// ----------------------------------------------------------------------------
module swhll_front #(
  parameter int MAX_PRECISION = swhll_pkg::DEF_MAX_PRECISION,
  parameter int TIME_BITS     = swhll_pkg::DEF_TIME_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [swhll_pkg::PREC_CFG_W-1:0]      cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_opcode,
  input  logic [swhll_pkg::HASH_W-1:0]          in_hash_value,
  input  logic [swhll_pkg::EVENT_TIME_W-1:0]    in_event_time,
  input  logic [swhll_pkg::INDEX_W-1:0]         in_register_index,
  input  logic [swhll_pkg::WIN_W-1:0]           in_window_length,
  input  logic                                  init_done,
  input  logic                                  q_full,
  output logic                                  q_push,
  output logic [swhll_pkg::cmd_width(MAX_PRECISION, TIME_BITS)-1:0] q_data
);

  localparam int PREC_W = $clog2(MAX_PRECISION + 1);
  localparam int SH_W   = $clog2(swhll_pkg::HASH_W + 1);
  localparam int HW     = swhll_pkg::HASH_W;
  localparam int RW     = swhll_pkg::RANK_W;

  swhll_pkg::front_state_t state_r, state_nxt;

  logic [swhll_pkg::PREC_CFG_W-1:0] precision_r;
  logic [PREC_W-1:0]                p_eff;
  logic                             accept;

  logic                         op_r, op_nxt;
  logic [MAX_PRECISION-1:0]     reg_r, reg_nxt;
  logic [TIME_BITS-1:0]         time_r, time_nxt;
  logic [swhll_pkg::WIN_W-1:0]  win_r, win_nxt;
  logic [HW-1:0]                rest_r, rest_nxt;
  logic [7:0]                   byte_nz_r, byte_nz_nxt;
  logic [7:0][2:0]              byte_lz_r, byte_lz_nxt;
  logic [RW-1:0]                rank_calc;
  logic [RW-1:0]                rank_out;
  logic                         found;

  function automatic logic [2:0] byte_lz(input logic [7:0] b);
    logic [2:0] n;
    logic       hit;
    n   = 3'd0;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit) begin
        if (b[i]) begin
          hit = 1'b1;
        end else begin
          n = n + 3'd1;
        end
      end
    end
    return n;
  endfunction

  always_comb begin
    if (int'(precision_r) < swhll_pkg::MIN_PRECISION) begin
      p_eff = PREC_W'(swhll_pkg::MIN_PRECISION);
    end else if (int'(precision_r) > MAX_PRECISION) begin
      p_eff = PREC_W'(MAX_PRECISION);
    end else begin
      p_eff = PREC_W'(precision_r);
    end
  end

  assign in_stall = !(state_r == swhll_pkg::F_IDLE && init_done);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    op_nxt   = in_opcode;
    time_nxt = TIME_BITS'(in_event_time);
    win_nxt  = in_window_length;
    // The sentinel bit below the hash remainder caps the rank at 65 - precision.
    rest_nxt = (in_hash_value << p_eff) | (HW'(1) << (p_eff - PREC_W'(1)));
    if (in_opcode == swhll_pkg::OP_INSERT) begin
      reg_nxt = MAX_PRECISION'(in_hash_value >> (SH_W'(HW) - SH_W'(p_eff)));
    end else begin
      reg_nxt = MAX_PRECISION'(HW'(in_register_index) & ~({HW{1'b1}} << p_eff));
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_nz_nxt[i] = |rest_r[8*i +: 8];
      byte_lz_nxt[i] = byte_lz(rest_r[8*i +: 8]);
    end
  end

  // The remainder always has the sentinel set, so some byte is nonzero.
  always_comb begin
    rank_calc = '0;
    found     = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && byte_nz_r[i]) begin
        found     = 1'b1;
        rank_calc = RW'(8 * (7 - i)) + RW'(byte_lz_r[i]) + RW'(1);
      end
    end
  end

  assign rank_out = (op_r == swhll_pkg::OP_QUERY) ? '0 : rank_calc;
  assign q_data   = {op_r, reg_r, rank_out, time_r, win_r};

  always_comb begin
    state_nxt = state_r;
    q_push    = 1'b0;
    case (state_r)
      swhll_pkg::F_IDLE: begin
        if (accept) begin
          state_nxt = swhll_pkg::F_ENC;
        end
      end
      swhll_pkg::F_ENC: begin
        state_nxt = swhll_pkg::F_RANK;
      end
      swhll_pkg::F_RANK: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = swhll_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = swhll_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swhll_pkg::F_IDLE;
      precision_r <= swhll_pkg::PRECISION_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        precision_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_nxt;
      reg_r  <= reg_nxt;
      time_r <= time_nxt;
      win_r  <= win_nxt;
      rest_r <= rest_nxt;
    end
    byte_nz_r <= byte_nz_nxt;
    byte_lz_r <= byte_lz_nxt;
  end

endmodule

// ===== hw/rtl/swhll_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// swhll_cmd_queue
// Short first-in first-out queue of commands between the front and back ends.
// ----------------------------------------------------------------------------
module swhll_cmd_queue #(
  parameter int DATA_W = swhll_pkg::cmd_width(swhll_pkg::DEF_MAX_PRECISION,
                                              swhll_pkg::DEF_TIME_BITS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              empty
);

  localparam int DEPTH = swhll_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full      = (fill_r == CNT_W'(DEPTH));
  assign empty     = (fill_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/swhll_back.sv =====
// ----------------------------------------------------------------------------
// swhll_back
// Executes queued commands against the point and entry-count memories, one
// stored point per cycle, and holds the result in the output register.
// ----------------------------------------------------------------------------
module swhll_back #(
  parameter int MAX_PRECISION        = swhll_pkg::DEF_MAX_PRECISION,
  parameter int ENTRIES_PER_REGISTER = swhll_pkg::DEF_ENTRIES_PER_REGISTER,
  parameter int TIME_BITS            = swhll_pkg::DEF_TIME_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  input  logic [swhll_pkg::cmd_width(MAX_PRECISION, TIME_BITS)-1:0] q_head,
  output logic                                  q_pop,
  output logic                                  init_done,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_done_kind,
  output logic [swhll_pkg::INDEX_W-1:0]         out_chosen_register,
  output logic [swhll_pkg::RANK_W-1:0]          out_insert_rank,
  output logic [swhll_pkg::RANK_W-1:0]          out_window_max
);

  localparam int E      = ENTRIES_PER_REGISTER;
  localparam int RW     = swhll_pkg::RANK_W;
  localparam int WW     = swhll_pkg::WIN_W;
  localparam int CMD_W  = swhll_pkg::cmd_width(MAX_PRECISION, TIME_BITS);
  localparam int SW     = $clog2(E);
  localparam int CW     = $clog2(E + 1);
  localparam int NREG   = 1 << MAX_PRECISION;
  localparam int AW     = MAX_PRECISION + SW;
  localparam int PW     = TIME_BITS + RW;
  localparam int CMP_W  = ((TIME_BITS > WW) ? TIME_BITS : WW) + 1;

  // Command layout, low to high: window, time, rank, register, opcode.
  localparam int TIME_LSB = WW;
  localparam int RANK_LSB = TIME_LSB + TIME_BITS;
  localparam int REG_LSB  = RANK_LSB + RW;
  localparam int OP_BIT   = REG_LSB + MAX_PRECISION;

  swhll_pkg::back_state_t state_r, state_nxt;

  logic [MAX_PRECISION-1:0] clr_addr_r, clr_addr_nxt;
  logic [CMD_W-1:0]         cur_r, cur_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            wr_r, wr_nxt;
  logic [RW-1:0]            best_r, best_nxt;

  logic                     cur_op;
  logic [MAX_PRECISION-1:0] cur_reg;
  logic [RW-1:0]            cur_rank;
  logic [TIME_BITS-1:0]     cur_time;
  logic [WW-1:0]            cur_win;

  logic [CW-1:0]            cnt_mem [NREG];
  logic                     cnt_we;
  logic [MAX_PRECISION-1:0] cnt_waddr;
  logic [CW-1:0]            cnt_wdata;
  logic [MAX_PRECISION-1:0] cnt_raddr;
  logic [CW-1:0]            cnt_q;

  logic [PW-1:0]            pt_mem [1 << AW];
  logic                     pt_we;
  logic [AW-1:0]            pt_waddr;
  logic [PW-1:0]            pt_wdata;
  logic [SW-1:0]            pt_rd_slot;
  logic [AW-1:0]            pt_raddr;
  logic [PW-1:0]            pt_q;
  logic [TIME_BITS-1:0]     pt_time;
  logic [RW-1:0]            pt_rank;
  logic                     in_window;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_load;
  logic                     out_kind_r;
  logic [swhll_pkg::INDEX_W-1:0] out_reg_r;
  logic [RW-1:0]            out_rank_r;
  logic [RW-1:0]            out_max_r;

  assign cur_op   = cur_r[OP_BIT];
  assign cur_reg  = cur_r[REG_LSB +: MAX_PRECISION];
  assign cur_rank = cur_r[RANK_LSB +: RW];
  assign cur_time = cur_r[TIME_LSB +: TIME_BITS];
  assign cur_win  = cur_r[0 +: WW];

  assign pt_time  = pt_q[RW +: TIME_BITS];
  assign pt_rank  = pt_q[0 +: RW];

  // time >= t - w, taken as time + w >= t so that the bound never wraps.
  assign in_window = (CMP_W'(pt_time) + CMP_W'(cur_win)) >= CMP_W'(cur_time);

  assign cnt_raddr = q_head[REG_LSB +: MAX_PRECISION];
  assign pt_raddr  = {cur_reg, pt_rd_slot};
  assign init_done = (state_r != swhll_pkg::B_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cur_nxt      = cur_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    wr_nxt       = wr_r;
    best_nxt     = best_r;
    q_pop        = 1'b0;
    cnt_we       = 1'b0;
    cnt_waddr    = cur_reg;
    cnt_wdata    = '0;
    pt_we        = 1'b0;
    pt_waddr     = {cur_reg, SW'(wr_r)};
    pt_wdata     = pt_q;
    pt_rd_slot   = SW'(idx_r + CW'(1));
    out_load     = 1'b0;
    case (state_r)
      swhll_pkg::B_CLEAR: begin
        cnt_we       = 1'b1;
        cnt_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + MAX_PRECISION'(1);
        if (clr_addr_r == {MAX_PRECISION{1'b1}}) begin
          state_nxt = swhll_pkg::B_IDLE;
        end
      end
      swhll_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head;
          state_nxt = swhll_pkg::B_COUNT;
        end
      end
      swhll_pkg::B_COUNT: begin
        // The count is back from memory; slot zero is being read meanwhile.
        pt_rd_slot = '0;
        cnt_nxt    = cnt_q;
        idx_nxt    = '0;
        wr_nxt     = '0;
        best_nxt   = '0;
        if (cnt_q == '0) begin
          state_nxt = swhll_pkg::B_APPEND;
        end else begin
          state_nxt = swhll_pkg::B_SCAN;
        end
      end
      swhll_pkg::B_SCAN: begin
        if (cur_op == swhll_pkg::OP_INSERT) begin
          // Points that outrank the new one are compacted toward slot zero.
          if (pt_rank > cur_rank) begin
            pt_we  = 1'b1;
            wr_nxt = wr_r + CW'(1);
          end
        end else if (in_window && pt_rank > best_r) begin
          best_nxt = pt_rank;
        end
        idx_nxt = idx_r + CW'(1);
        if (idx_r == cnt_r - CW'(1)) begin
          state_nxt = swhll_pkg::B_APPEND;
        end
      end
      swhll_pkg::B_APPEND: begin
        if (cur_op == swhll_pkg::OP_INSERT) begin
          pt_we    = 1'b1;
          pt_wdata = {cur_time, cur_rank};
          cnt_we   = 1'b1;
          // A full register with nothing dropped loses its newest point.
          if (wr_r == CW'(E)) begin
            pt_waddr  = {cur_reg, SW'(E - 1)};
            cnt_wdata = CW'(E);
          end else begin
            cnt_wdata = wr_r + CW'(1);
          end
        end
        state_nxt = swhll_pkg::B_DONE;
      end
      swhll_pkg::B_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = swhll_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = swhll_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swhll_pkg::B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    wr_r   <= wr_nxt;
    best_r <= best_nxt;
    if (out_load) begin
      out_kind_r <= cur_op;
      out_reg_r  <= swhll_pkg::INDEX_W'(cur_reg);
      out_rank_r <= (cur_op == swhll_pkg::OP_INSERT) ? cur_rank : '0;
      out_max_r  <= (cur_op == swhll_pkg::OP_QUERY) ? best_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_q <= pt_mem[pt_raddr];
  end

  assign out_valid           = out_valid_r;
  assign out_done_kind       = out_kind_r;
  assign out_chosen_register = out_reg_r;
  assign out_insert_rank     = out_rank_r;
  assign out_window_max      = out_max_r;

endmodule

// ===== hw/rtl/sliding_window_hll_register_store.sv =====
// ----------------------------------------------------------------------------
// sliding_window_hll_register_store
// Flow: the front end registers an accepted transaction (F_ENC, F_RANK) and
//   queues it; the back end walks the N points of the addressed register
//   (0 to ENTRIES_PER_REGISTER) one per cycle through the point memory read
//   port. The front end can accept a new transaction while the back end works.
// Reset: synchronous, active low. A clearing pass over all 2^MAX_PRECISION
//   entry counts (4096 by default) zeroes them; input stalls until it ends.
// ----------------------------------------------------------------------------
module sliding_window_hll_register_store #(
  parameter int MAX_PRECISION        = swhll_pkg::DEF_MAX_PRECISION,
  parameter int ENTRIES_PER_REGISTER = swhll_pkg::DEF_ENTRIES_PER_REGISTER,
  parameter int TIME_BITS            = swhll_pkg::DEF_TIME_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [swhll_pkg::PREC_CFG_W-1:0]   cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_opcode,
  input  logic [swhll_pkg::HASH_W-1:0]       in_hash_value,
  input  logic [swhll_pkg::EVENT_TIME_W-1:0] in_event_time,
  input  logic [swhll_pkg::INDEX_W-1:0]      in_register_index,
  input  logic [swhll_pkg::WIN_W-1:0]        in_window_length,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_done_kind,
  output logic [swhll_pkg::INDEX_W-1:0]      out_chosen_register,
  output logic [swhll_pkg::RANK_W-1:0]       out_insert_rank,
  output logic [swhll_pkg::RANK_W-1:0]       out_window_max
);

  localparam int CMD_W = swhll_pkg::cmd_width(MAX_PRECISION, TIME_BITS);

  logic             init_done;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic [CMD_W-1:0] q_push_data;
  logic [CMD_W-1:0] q_head_data;

  swhll_front #(
    .MAX_PRECISION (MAX_PRECISION),
    .TIME_BITS     (TIME_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_hash_value     (in_hash_value),
    .in_event_time     (in_event_time),
    .in_register_index (in_register_index),
    .in_window_length  (in_window_length),
    .init_done         (init_done),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_push_data)
  );

  swhll_cmd_queue #(
    .DATA_W (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (q_head_data),
    .empty     (q_empty)
  );

  swhll_back #(
    .MAX_PRECISION        (MAX_PRECISION),
    .ENTRIES_PER_REGISTER (ENTRIES_PER_REGISTER),
    .TIME_BITS            (TIME_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head_data),
    .q_pop               (q_pop),
    .init_done           (init_done),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_done_kind       (out_done_kind),
    .out_chosen_register (out_chosen_register),
    .out_insert_rank     (out_insert_rank),
    .out_window_max      (out_window_max)
  );

  // No transaction may enter while the entry counts are still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> init_done)
    else $error("input accepted during the clearing pass");

  // The front end only pushes into a queue with room.
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  // The back end only takes a command that is there.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  // An insert result carries a nonzero rank and no window maximum.
  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_kind == swhll_pkg::OP_INSERT)
      |-> (out_window_max == '0 && out_insert_rank != '0))
    else $error("malformed insert result");

  // A query result carries no insert rank.
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_kind == swhll_pkg::OP_QUERY) |-> (out_insert_rank == '0))
    else $error("malformed query result");

endmodule
